[rtl/crcd_pkg.sv]
// Package for the control report change detector.
// Holds the report layout constants, register indexes and shared types.
// No dependencies.
package crcd_pkg;

    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned DATA_W = 8;
    localparam int unsigned POS_W = 4;
    localparam int unsigned NUM_FADERS = 4;

    localparam logic [CFG_INDEX_W-1:0] CFG_REPORT_ID = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FADER_LIMIT = 1'd1;

    localparam logic [DATA_W-1:0] REPORT_ID_RESET = 8'd9;
    localparam logic [DATA_W-1:0] FADER_LIMIT_RESET = 8'd100;

    localparam logic [POS_W-1:0] POS_ID = 4'd0;
    localparam logic [POS_W-1:0] POS_BUTTONS = 4'd1;
    localparam logic [POS_W-1:0] POS_FADER_FIRST = 4'd3;
    localparam logic [POS_W-1:0] POS_FADER_LAST = 4'd6;
    localparam logic [POS_W-1:0] POS_REPORT_END = 4'd7;
    localparam logic [POS_W-1:0] POS_MAX = 4'd15;

    typedef logic [DATA_W-1:0] byte_t;
    typedef byte_t [NUM_FADERS-1:0] fader_set_t;

endpackage

[rtl/control_report_change_detector.sv]
// Control report change detector: assembles 8-byte reports and flags button
// presses and fader changes. Depends on crcd_pkg.
// The result is registered and appears in the output register in the cycle
// after the transfer of the last report byte. Throughput: one byte per cycle
// while the output register is empty or being drained in the same cycle.
// Reset: report_id to 9, fader_limit to 100; all else clears but output data.
module control_report_change_detector (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [crcd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [crcd_pkg::DATA_W-1:0]        cfg_data,
    input  logic                               byte_valid,
    output logic                               byte_ready,
    input  logic [crcd_pkg::DATA_W-1:0]        report_byte,
    input  logic                               last_byte,
    output logic                               result_valid,
    input  logic                               result_ready,
    output logic [crcd_pkg::DATA_W-1:0]        pressed,
    output logic                               faders_valid,
    output logic [crcd_pkg::NUM_FADERS-1:0]    fader_changed,
    output logic [crcd_pkg::DATA_W-1:0]        fader_0,
    output logic [crcd_pkg::DATA_W-1:0]        fader_1,
    output logic [crcd_pkg::DATA_W-1:0]        fader_2,
    output logic [crcd_pkg::DATA_W-1:0]        fader_3
);
    import crcd_pkg::*;

    byte_t                 report_id_reg;
    byte_t                 fader_limit_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [POS_W-1:0]      pos_next;
    logic                  id_matched_reg;
    logic                  id_matched_next;
    byte_t                 buttons_reg;
    byte_t                 buttons_next;
    fader_set_t            faders_reg;
    fader_set_t            faders_next;
    byte_t                 prev_buttons_reg;
    byte_t                 prev_buttons_next;
    fader_set_t            prev_faders_reg;
    fader_set_t            prev_faders_next;
    logic                  have_prev_reg;
    logic                  have_prev_next;
    logic                  reporting_reg;
    logic                  reporting_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    byte_t                 pressed_reg;
    byte_t                 pressed_next;
    logic                  fvalid_reg;
    logic                  fvalid_next;
    logic [NUM_FADERS-1:0] changed_reg;
    logic [NUM_FADERS-1:0] changed_next;
    fader_set_t            vals_reg;
    fader_set_t            vals_next;

    logic                  transfer;
    logic                  emit;
    logic                  all_in_limit;
    logic                  any_nonzero;
    logic                  fader_update;
    logic [1:0]            fader_slot;

    assign byte_ready = !out_valid_reg || result_ready;
    assign transfer = byte_valid && byte_ready;
    assign emit = transfer && last_byte && (pos_reg == POS_REPORT_END) && id_matched_reg;
    assign fader_slot = pos_reg[1:0] - POS_FADER_FIRST[1:0];

    always_comb
    begin
        all_in_limit = 1'b1;
        any_nonzero = 1'b0;
        for (int i = 0; i < NUM_FADERS; i++)
        begin
            if (faders_reg[i] > fader_limit_reg)
            begin
                all_in_limit = 1'b0;
            end
            if (faders_reg[i] != '0)
            begin
                any_nonzero = 1'b1;
            end
        end
        fader_update = all_in_limit && (reporting_reg || any_nonzero);
    end

    always_comb
    begin
        pos_next = pos_reg;
        id_matched_next = id_matched_reg;
        buttons_next = buttons_reg;
        faders_next = faders_reg;
        prev_buttons_next = prev_buttons_reg;
        prev_faders_next = prev_faders_reg;
        have_prev_next = have_prev_reg;
        reporting_next = reporting_reg;
        out_valid_next = out_valid_reg && !result_ready;
        pressed_next = pressed_reg;
        fvalid_next = fvalid_reg;
        changed_next = changed_reg;
        vals_next = vals_reg;

        if (transfer)
        begin
            if (pos_reg == POS_ID)
            begin
                id_matched_next = (report_byte == report_id_reg);
            end
            else if (pos_reg == POS_BUTTONS)
            begin
                buttons_next = report_byte;
            end
            else if (pos_reg >= POS_FADER_FIRST && pos_reg <= POS_FADER_LAST)
            begin
                faders_next[fader_slot] = report_byte;
            end

            if (last_byte)
            begin
                pos_next = POS_ID;
                id_matched_next = 1'b0;
            end
            else if (pos_reg != POS_MAX)
            begin
                pos_next = pos_reg + 1'b1;
            end
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
            pressed_next = buttons_reg & ~prev_buttons_reg;
            fvalid_next = all_in_limit;
            changed_next = '0;
            vals_next = '0;
            prev_buttons_next = buttons_reg;
            if (fader_update)
            begin
                reporting_next = 1'b1;
                have_prev_next = 1'b1;
                prev_faders_next = faders_reg;
                for (int i = 0; i < NUM_FADERS; i++)
                begin
                    if (have_prev_reg && (prev_faders_reg[i] != faders_reg[i]))
                    begin
                        changed_next[i] = 1'b1;
                        vals_next[i] = faders_reg[i];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            report_id_reg <= REPORT_ID_RESET;
            fader_limit_reg <= FADER_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_REPORT_ID: report_id_reg <= cfg_data;
                CFG_FADER_LIMIT: fader_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            id_matched_reg <= 1'b0;
            buttons_reg <= '0;
            faders_reg <= '0;
            prev_buttons_reg <= '0;
            prev_faders_reg <= '0;
            have_prev_reg <= 1'b0;
            reporting_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            id_matched_reg <= id_matched_next;
            buttons_reg <= buttons_next;
            faders_reg <= faders_next;
            prev_buttons_reg <= prev_buttons_next;
            prev_faders_reg <= prev_faders_next;
            have_prev_reg <= have_prev_next;
            reporting_reg <= reporting_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pressed_reg <= pressed_next;
        fvalid_reg <= fvalid_next;
        changed_reg <= changed_next;
        vals_reg <= vals_next;
    end

    assign result_valid = out_valid_reg;
    assign pressed = pressed_reg;
    assign faders_valid = fvalid_reg;
    assign fader_changed = changed_reg;
    assign fader_0 = vals_reg[0];
    assign fader_1 = vals_reg[1];
    assign fader_2 = vals_reg[2];
    assign fader_3 = vals_reg[3];

endmodule

[rtl/crcd_checker.sv]
// Port-level checker for the control report change detector.
// Depends on crcd_pkg; bound to control_report_change_detector below.
module crcd_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               byte_valid,
    input logic                               byte_ready,
    input logic                               last_byte,
    input logic                               result_valid,
    input logic                               result_ready,
    input logic                               faders_valid,
    input logic [crcd_pkg::NUM_FADERS-1:0]    fader_changed,
    input logic [crcd_pkg::DATA_W-1:0]        fader_0,
    input logic [crcd_pkg::DATA_W-1:0]        fader_1,
    input logic [crcd_pkg::DATA_W-1:0]        fader_2,
    input logic [crcd_pkg::DATA_W-1:0]        fader_3
);
    import crcd_pkg::*;

    // A pending result that is not taken stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped while stalled");

    // With the output register empty the block always takes a byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> byte_ready)
        else $error("byte_ready low with empty output register");

    // A new result only follows the transfer of a closing byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(byte_valid && byte_ready && last_byte))
        else $error("result without a closing byte transfer");

    // Changes are only flagged on a valid fader set.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (fader_changed != '0) |-> faders_valid)
        else $error("fader change flagged on an invalid set");

    // A fader that is not flagged reads as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (fader_changed[0] || fader_0 == '0)
            && (fader_changed[1] || fader_1 == '0)
            && (fader_changed[2] || fader_2 == '0)
            && (fader_changed[3] || fader_3 == '0))
        else $error("unflagged fader value is nonzero");

endmodule

bind control_report_change_detector crcd_checker u_crcd_checker (
    .clk(clk),
    .rst_n(rst_n),
    .byte_valid(byte_valid),
    .byte_ready(byte_ready),
    .last_byte(last_byte),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .faders_valid(faders_valid),
    .fader_changed(fader_changed),
    .fader_0(fader_0),
    .fader_1(fader_1),
    .fader_2(fader_2),
    .fader_3(fader_3)
);
